// ===== src/swtp_pkg.sv =====
package swtp_pkg;

  // Pool size and derived widths.
  localparam int unsigned SlotCount = 16;
  localparam int unsigned CntW      = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  // Field widths.
  localparam int unsigned KindW  = 2;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned ValW   = 16;
  localparam int unsigned TicksW = 32;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  // Request kinds.
  localparam logic [KindW-1:0] ReqTick  = 2'd0;
  localparam logic [KindW-1:0] ReqAdd   = 2'd1;
  localparam logic [KindW-1:0] ReqDel   = 2'd2;
  localparam logic [KindW-1:0] ReqStart = 2'd3;

  // One timer slot as it travels along the ring of cells.
  typedef struct packed {
    logic              used;
    logic              start_cb;
    logic              stop_cb;
    logic [ValW-1:0]   mult;
    logic [TicksW-1:0] ticks;
  } slot_rec_t;

  // Latched request.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdxW-1:0]  idx;
    logic [ValW-1:0]  reload;
    logic [ValW-1:0]  mult;
    logic             start_en;
    logic             stop_en;
  } req_t;

  // What the update unit saw on the slot passing through it.
  typedef struct packed {
    logic found;
    logic start;
    logic expire;
  } hit_t;

endpackage

// ===== src/software_timer_pool_unit.sv =====
// Pool of one-shot down-counting timers. Each request (tick, add, delete,
// start) is one transfer on the slave side and yields exactly one result
// transfer on the master side. The slot records sit in a ring of cells and
// rotate one cell per cycle past a single update unit while the sweep is not
// held. A request occupies the block for one full turn of the ring, and the
// slave side takes no new request until that turn is done. A waiting result
// does not block the next request; the last rotation step only holds while
// an earlier result is still untaken.
module software_timer_pool_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: slot_index[4:0], reload_value[20:5], period_multiplier[36:21],
  //        start_enable[37], stop_enable[38], zero[39]
  input  logic [39:0] s_axis_tdata_i,
  // tuser: req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: add_ok[0], added_slot[4:1], start_event[5], expired_mask[21:6], zero[23:22]
  output logic [23:0] m_axis_tdata_o
);

  localparam int unsigned N = swtp_pkg::SlotCount;

  swtp_pkg::req_t                 req_q;
  logic                           busy_q;
  logic [swtp_pkg::CntW-1:0]      cnt_q;
  logic                           found_q, found_d;
  logic [swtp_pkg::SlotW-1:0]     slot_q, slot_d;
  logic                           start_q, start_d;
  logic [swtp_pkg::MaskW-1:0]     mask_q, mask_d;
  logic                           out_valid_q;
  logic [swtp_pkg::OutDataW-1:0]  out_data_q;
  logic                           accept, last, step_en, out_take;
  swtp_pkg::slot_rec_t            ring [N];
  swtp_pkg::slot_rec_t            upd_rec;
  swtp_pkg::hit_t                 hit;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !busy_q;
  assign last            = (cnt_q == swtp_pkg::CntW'(N - 1));
  assign out_take        = out_valid_q && m_axis_tready_i;
  // The final step waits until the output register is free.
  assign step_en         = busy_q && !(last && out_valid_q && !m_axis_tready_i);

  // Ring of slot cells; the update unit closes the loop.
  for (genvar j = 0; j < N; j++) begin : g_cell
    swtp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (step_en),
      .rec_i   ((j == 0) ? upd_rec : ring[(j == 0) ? 0 : j - 1]),
      .rec_o   (ring[j])
    );
  end

  swtp_update u_update (
    .req_i   (req_q),
    .slot_i  (cnt_q),
    .found_i (found_q),
    .rec_i   (ring[N-1]),
    .rec_o   (upd_rec),
    .hit_o   (hit)
  );

  // Result accumulation including the slot handled this cycle.
  always_comb begin
    found_d = found_q | hit.found;
    slot_d  = hit.found ? swtp_pkg::SlotW'(cnt_q) : slot_q;
    start_d = start_q | hit.start;
    mask_d  = mask_q | (hit.expire ? (swtp_pkg::MaskW'(1) << cnt_q) : '0);
  end

  // Request register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.kind     <= s_axis_tuser_i;
      req_q.idx      <= s_axis_tdata_i[4:0];
      req_q.reload   <= s_axis_tdata_i[20:5];
      req_q.mult     <= s_axis_tdata_i[36:21];
      req_q.start_en <= s_axis_tdata_i[37];
      req_q.stop_en  <= s_axis_tdata_i[38];
    end
  end

  // Sweep control and result accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      found_q <= 1'b0;
      slot_q  <= '0;
      start_q <= 1'b0;
      mask_q  <= '0;
    end else if (accept) begin
      busy_q  <= 1'b1;
      cnt_q   <= '0;
      found_q <= 1'b0;
      slot_q  <= '0;
      start_q <= 1'b0;
      mask_q  <= '0;
    end else if (step_en) begin
      found_q <= found_d;
      slot_q  <= slot_d;
      start_q <= start_d;
      mask_q  <= mask_d;
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + swtp_pkg::CntW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en && last) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && last) begin
      out_data_q <= {2'b00, mask_d, start_d, slot_d, found_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // A new request always starts its sweep at slot zero.
  a_sweep_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && cnt_q == '0)
    else $error("sweep did not start at slot zero");

  // A result appears only at the end of a sweep.
  a_result_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q && last))
    else $error("result produced outside the final sweep step");

  // The sweep counter never passes the last slot.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= swtp_pkg::CntW'(N - 1))
    else $error("sweep counter out of range");

  // A failed add reports slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q[0] |-> out_data_q[4:1] == '0)
    else $error("slot reported without a successful add");

  // Expiry bits never come with add or start results.
  a_mask_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[21:6] != '0 |-> !out_data_q[0] && !out_data_q[5])
    else $error("expiry mask mixed with another request kind");

endmodule

// ===== src/swtp_cell.sv =====
module swtp_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  swtp_pkg::slot_rec_t rec_i,
  output swtp_pkg::slot_rec_t rec_o
);

  logic                          used_q, start_q, stop_q;
  logic [swtp_pkg::ValW-1:0]     mult_q;
  logic [swtp_pkg::TicksW-1:0]   ticks_q;

  // Flags and counter take the neighbor's record on every shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      start_q <= 1'b0;
      stop_q  <= 1'b0;
      ticks_q <= '0;
    end else if (shift_i) begin
      used_q  <= rec_i.used;
      start_q <= rec_i.start_cb;
      stop_q  <= rec_i.stop_cb;
      ticks_q <= rec_i.ticks;
    end
  end

  // The multiplier is payload and is only meaningful once an add wrote it.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      mult_q <= rec_i.mult;
    end
  end

  assign rec_o.used     = used_q;
  assign rec_o.start_cb = start_q;
  assign rec_o.stop_cb  = stop_q;
  assign rec_o.mult     = mult_q;
  assign rec_o.ticks    = ticks_q;

endmodule

// ===== src/swtp_update.sv =====
module swtp_update (
  input  swtp_pkg::req_t               req_i,
  input  logic [swtp_pkg::CntW-1:0]    slot_i,
  input  logic                         found_i,
  input  swtp_pkg::slot_rec_t          rec_i,
  output swtp_pkg::slot_rec_t          rec_o,
  output swtp_pkg::hit_t               hit_o
);

  logic                      idx_match;
  logic [swtp_pkg::ValW-1:0] add_mult;

  assign idx_match = (req_i.idx == swtp_pkg::IdxW'(slot_i));
  assign add_mult  = (req_i.mult == '0) ? swtp_pkg::ValW'(1) : req_i.mult;

  // Apply the request to the one slot passing through.
  always_comb begin
    rec_o = rec_i;
    hit_o = '0;
    unique case (req_i.kind)
      swtp_pkg::ReqTick: begin
        if (rec_i.used && rec_i.ticks != '0) begin
          rec_o.ticks  = rec_i.ticks - swtp_pkg::TicksW'(1);
          hit_o.expire = rec_i.stop_cb && (rec_i.ticks == swtp_pkg::TicksW'(1));
        end
      end
      swtp_pkg::ReqAdd: begin
        if (!rec_i.used && !found_i) begin
          rec_o.used     = 1'b1;
          rec_o.mult     = add_mult;
          rec_o.start_cb = req_i.start_en;
          rec_o.stop_cb  = req_i.stop_en;
          hit_o.found    = 1'b1;
        end
      end
      swtp_pkg::ReqDel: begin
        if (idx_match) begin
          rec_o.used     = 1'b0;
          rec_o.start_cb = 1'b0;
          rec_o.stop_cb  = 1'b0;
        end
      end
      swtp_pkg::ReqStart: begin
        if (idx_match && rec_i.used) begin
          rec_o.ticks = swtp_pkg::TicksW'(req_i.reload) * swtp_pkg::TicksW'(rec_i.mult);
          hit_o.start = rec_i.start_cb;
        end
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end

endmodule
